// ===== rtl/fixed_point_alu_defines.svh =====
// Assertion macros used by fpa_back.
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH
`ifndef ASSERT_OFF
`define FPA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fixed_point_alu: assertion failed");
`define FPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fixed_point_alu: assertion failed");
`else
`define FPA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define FPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/fpa_pkg.sv =====
package fpa_pkg;
	localparam int MAX_WIDTH = 64;
	localparam int DEF_DATA_WIDTH = 32;
	localparam int DEF_FRAC_BITS = 8;
	localparam int FIELD_WIDTH = 32;
	localparam int ACTION_WIDTH = 4;

	localparam logic [ACTION_WIDTH-1:0] ACT_ADD = 4'd0;
	localparam logic [ACTION_WIDTH-1:0] ACT_SUB = 4'd1;
	localparam logic [ACTION_WIDTH-1:0] ACT_MUL = 4'd2;
	localparam logic [ACTION_WIDTH-1:0] ACT_DIV = 4'd3;
	localparam logic [ACTION_WIDTH-1:0] ACT_MIN = 4'd4;
	localparam logic [ACTION_WIDTH-1:0] ACT_MAX = 4'd5;
	localparam logic [ACTION_WIDTH-1:0] ACT_INC = 4'd6;
	localparam logic [ACTION_WIDTH-1:0] ACT_DEC = 4'd7;
	localparam logic [ACTION_WIDTH-1:0] ACT_I2F = 4'd8;
	localparam logic [ACTION_WIDTH-1:0] ACT_F2I = 4'd9;

	localparam logic [1:0] KIND_SIMPLE = 2'd0;
	localparam logic [1:0] KIND_MUL = 2'd1;
	localparam logic [1:0] KIND_DIV = 2'd2;

	typedef struct packed {
		logic [ACTION_WIDTH-1:0] action;
		logic [1:0] kind;
		logic [MAX_WIDTH-1:0] a;
		logic [MAX_WIDTH-1:0] b;
		logic lt;
		logic eq;
		logic gt;
		logic dz;
	} fpa_entry_t;

	typedef struct packed {
		logic valid;
		fpa_entry_t entry;
	} fpa_head_t;
endpackage

// ===== rtl/fpa_front.sv =====
module fpa_front #(
	parameter int DATA_WIDTH = fpa_pkg::DEF_DATA_WIDTH
) (
	input logic [fpa_pkg::ACTION_WIDTH-1:0] action,
	input logic signed [fpa_pkg::FIELD_WIDTH-1:0] operand_a,
	input logic signed [fpa_pkg::FIELD_WIDTH-1:0] operand_b,
	output fpa_pkg::fpa_entry_t entry
);
	logic signed [fpa_pkg::MAX_WIDTH-1:0] a_ext, b_ext;
	logic [DATA_WIDTH-1:0] a_w, b_w;
	logic dz;

	assign a_ext = fpa_pkg::MAX_WIDTH'(operand_a);
	assign b_ext = fpa_pkg::MAX_WIDTH'(operand_b);
	assign a_w = a_ext[DATA_WIDTH-1:0];
	assign b_w = b_ext[DATA_WIDTH-1:0];
	assign dz = (action == fpa_pkg::ACT_DIV) && (b_w == '0);

	always_comb begin
		entry.action = action;
		entry.a = fpa_pkg::MAX_WIDTH'(a_w);
		entry.b = fpa_pkg::MAX_WIDTH'(b_w);
		entry.lt = $signed(a_w) < $signed(b_w);
		entry.eq = a_w == b_w;
		entry.gt = $signed(a_w) > $signed(b_w);
		entry.dz = dz;
		if (action == fpa_pkg::ACT_MUL) begin
			entry.kind = fpa_pkg::KIND_MUL;
		end else if (action == fpa_pkg::ACT_DIV && !dz) begin
			entry.kind = fpa_pkg::KIND_DIV;
		end else begin
			entry.kind = fpa_pkg::KIND_SIMPLE;
		end
	end
endmodule

// ===== rtl/fpa_queue.sv =====
module fpa_queue (
	input logic clk,
	input logic arst_n,
	input logic push_en,
	input fpa_pkg::fpa_entry_t entry_in,
	output logic full,
	output fpa_pkg::fpa_head_t head,
	input logic pop_en
);
	fpa_pkg::fpa_entry_t ent0_q, ent1_q;
	logic [1:0] cnt_q;
	logic do_pop;

	assign full = cnt_q == 2'd2;
	assign do_pop = pop_en && (cnt_q != 2'd0);
	assign head.valid = cnt_q != 2'd0;
	assign head.entry = ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push_en) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			ent0_q <= (push_en && cnt_q == 2'd1) ? entry_in : ent1_q;
			if (push_en && cnt_q == 2'd2) begin
				ent1_q <= entry_in;
			end
		end else if (push_en) begin
			if (cnt_q == 2'd0) begin
				ent0_q <= entry_in;
			end else begin
				ent1_q <= entry_in;
			end
		end
	end
endmodule

// ===== rtl/fpa_back.sv =====
`include "fixed_point_alu_defines.svh"
module fpa_back #(
	parameter int DATA_WIDTH = fpa_pkg::DEF_DATA_WIDTH,
	parameter int FRAC_BITS = fpa_pkg::DEF_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	input fpa_pkg::fpa_head_t head,
	output logic q_pop,
	input logic pop,
	output logic out_valid,
	output logic [DATA_WIDTH-1:0] res,
	output logic lt,
	output logic eq,
	output logic gt,
	output logic dz
);
	localparam int NB = DATA_WIDTH + FRAC_BITS;
	localparam int CW = $clog2(NB + 1);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic state_q, is_div_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [2*DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] mca_q, rem_q, quo_q;
	logic [NB-1:0] dvd_q;
	logic fl_lt_q, fl_eq_q, fl_gt_q;
	logic out_valid_q, lt_q, eq_q, gt_q, dz_q;
	logic [DATA_WIDTH-1:0] res_q;

	logic [DATA_WIDTH-1:0] a, b, ma, mb, simple_res, long_res;
	logic [DATA_WIDTH:0] msum, rsh;
	logic ge, out_free, start, finish;
	logic [2*DATA_WIDTH-1:0] prod;

	assign a = head.entry.a[DATA_WIDTH-1:0];
	assign b = head.entry.b[DATA_WIDTH-1:0];
	assign ma = a[DATA_WIDTH-1] ? -a : a;
	assign mb = b[DATA_WIDTH-1] ? -b : b;
	assign out_free = !out_valid_q || pop;
	assign start = (state_q == ST_IDLE) && head.valid && out_free;
	assign q_pop = start;
	assign finish = (state_q == ST_BUSY) && (cnt_q == '0) && out_free;

	always_comb begin
		unique case (head.entry.action)
			fpa_pkg::ACT_ADD: simple_res = a + b;
			fpa_pkg::ACT_SUB: simple_res = a - b;
			fpa_pkg::ACT_MIN: simple_res = head.entry.lt ? a : b;
			fpa_pkg::ACT_MAX: simple_res = head.entry.gt ? a : b;
			fpa_pkg::ACT_INC: simple_res = a + DATA_WIDTH'(1);
			fpa_pkg::ACT_DEC: simple_res = a - DATA_WIDTH'(1);
			fpa_pkg::ACT_I2F: simple_res = a << FRAC_BITS;
			fpa_pkg::ACT_F2I: simple_res = DATA_WIDTH'($signed(a) >>> FRAC_BITS);
			default: simple_res = '0;
		endcase
	end

	assign msum = {1'b0, acc_q[2*DATA_WIDTH-1:DATA_WIDTH]}
		+ (acc_q[0] ? {1'b0, mca_q} : '0);
	assign rsh = {rem_q, dvd_q[NB-1]};
	assign ge = rsh >= {1'b0, mca_q};
	assign prod = neg_q ? -acc_q : acc_q;

	always_comb begin
		if (is_div_q) begin
			long_res = neg_q ? -quo_q : quo_q;
		end else begin
			long_res = prod[FRAC_BITS +: DATA_WIDTH];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (start && head.entry.kind != fpa_pkg::KIND_SIMPLE) begin
				state_q <= ST_BUSY;
				cnt_q <= (head.entry.kind == fpa_pkg::KIND_DIV) ? CW'(NB) : CW'(DATA_WIDTH);
			end else if (state_q == ST_BUSY && cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end else if (finish) begin
				state_q <= ST_IDLE;
			end
			if ((start && head.entry.kind == fpa_pkg::KIND_SIMPLE) || finish) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && head.entry.kind != fpa_pkg::KIND_SIMPLE) begin
			is_div_q <= head.entry.kind == fpa_pkg::KIND_DIV;
			neg_q <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
			fl_lt_q <= head.entry.lt;
			fl_eq_q <= head.entry.eq;
			fl_gt_q <= head.entry.gt;
			if (head.entry.kind == fpa_pkg::KIND_DIV) begin
				mca_q <= mb;
				dvd_q <= NB'(ma) << FRAC_BITS;
				rem_q <= '0;
				quo_q <= '0;
			end else begin
				mca_q <= ma;
				acc_q <= {{DATA_WIDTH{1'b0}}, mb};
			end
		end else if (state_q == ST_BUSY && cnt_q != '0) begin
			if (is_div_q) begin
				rem_q <= ge ? DATA_WIDTH'(rsh - {1'b0, mca_q}) : rsh[DATA_WIDTH-1:0];
				quo_q <= {quo_q[DATA_WIDTH-2:0], ge};
				dvd_q <= dvd_q << 1;
			end else begin
				acc_q <= {msum, acc_q[DATA_WIDTH-1:1]};
			end
		end
		if (start && head.entry.kind == fpa_pkg::KIND_SIMPLE) begin
			res_q <= simple_res;
			lt_q <= head.entry.lt;
			eq_q <= head.entry.eq;
			gt_q <= head.entry.gt;
			dz_q <= head.entry.dz;
		end else if (finish) begin
			res_q <= long_res;
			lt_q <= fl_lt_q;
			eq_q <= fl_eq_q;
			gt_q <= fl_gt_q;
			dz_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign res = res_q;
	assign lt = lt_q;
	assign eq = eq_q;
	assign gt = gt_q;
	assign dz = dz_q;

	`FPA_ASSERT_IMPLY(a_cnt_busy, clk, arst_n, cnt_q != '0, state_q == ST_BUSY)
	`FPA_ASSERT_IMPLY(a_start_idle, clk, arst_n, q_pop, state_q == ST_IDLE && head.valid)
	`FPA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid_q && !pop, out_valid_q)
	`FPA_ASSERT_IMPLY(a_one_flag, clk, arst_n, out_valid_q, $onehot({lt_q, eq_q, gt_q}))
endmodule

// ===== rtl/fixed_point_alu.sv =====
// Channel   Handshake      Beat fields
// input     push / full    action, operand_a, operand_b
// result    pop / empty    result, a_less, a_equal, a_greater, div_by_zero
//
// Simple operations and a divide by zero leave the queue one per cycle while each result
// is popped as it is shown; the result register is loaded from the queue head once the
// back end is free. A multiply or a divide holds the back end busy, taking no further
// beat from the queue, until its result is registered. Both are bit-serial units.
// A two-entry queue sits between decode and execute; full rises when it holds two beats,
// and a result that is not popped stalls the back end. Reset empties the queue and the
// result register.
module fixed_point_alu #(
	parameter int DATA_WIDTH = fpa_pkg::DEF_DATA_WIDTH,
	parameter int FRAC_BITS = fpa_pkg::DEF_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [fpa_pkg::ACTION_WIDTH-1:0] action,
	input logic signed [fpa_pkg::FIELD_WIDTH-1:0] operand_a,
	input logic signed [fpa_pkg::FIELD_WIDTH-1:0] operand_b,
	output logic empty,
	input logic pop,
	output logic signed [fpa_pkg::FIELD_WIDTH-1:0] result,
	output logic a_less,
	output logic a_equal,
	output logic a_greater,
	output logic div_by_zero
);
	fpa_pkg::fpa_entry_t entry;
	fpa_pkg::fpa_head_t head;
	logic q_full, q_pop, out_valid;
	logic [DATA_WIDTH-1:0] res;

	fpa_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.action(action),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.entry(entry)
	);

	fpa_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_en(push && !q_full),
		.entry_in(entry),
		.full(q_full),
		.head(head),
		.pop_en(q_pop)
	);

	fpa_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_pop(q_pop),
		.pop(pop && out_valid),
		.out_valid(out_valid),
		.res(res),
		.lt(a_less),
		.eq(a_equal),
		.gt(a_greater),
		.dz(div_by_zero)
	);

	assign full = q_full;
	assign empty = !out_valid;
	assign result = fpa_pkg::FIELD_WIDTH'($signed(res));
endmodule

// ===== dv/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = fpa_pkg::DEF_FRAC_BITS;
	localparam int LIMIT = 600000;

	typedef struct {
		logic [31:0] value;
		logic lt;
		logic eq;
		logic gt;
		logic dz;
	} alu_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [fpa_pkg::ACTION_WIDTH-1:0] action = fpa_pkg::ACT_ADD;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic full, empty, a_less, a_equal, a_greater, div_by_zero;
	logic signed [31:0] result;

	alu_answer_t answers_due[$];
	int mismatches = 0;
	int beats_checked = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	fixed_point_alu dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic alu_answer_t compute_alu(logic [3:0] op, logic signed [31:0] a,
			logic signed [31:0] b);
		alu_answer_t r;
		logic signed [63:0] prod;
		logic signed [63:0] num;
		logic signed [63:0] quo;
		r.lt = a < b;
		r.eq = a == b;
		r.gt = a > b;
		r.dz = 1'b0;
		prod = 64'(a) * 64'(b);
		case (op)
			fpa_pkg::ACT_ADD: r.value = a + b;
			fpa_pkg::ACT_SUB: r.value = a - b;
			fpa_pkg::ACT_MUL: r.value = 32'(prod >>> FRAC);
			fpa_pkg::ACT_DIV: begin
				if (b == 0) begin
					r.dz = 1'b1;
					r.value = '0;
				end else begin
					num = 64'(a) <<< FRAC;
					quo = num / 64'(b);
					r.value = quo[31:0];
				end
			end
			fpa_pkg::ACT_MIN: r.value = r.lt ? a : b;
			fpa_pkg::ACT_MAX: r.value = r.gt ? a : b;
			fpa_pkg::ACT_INC: r.value = a + 1;
			fpa_pkg::ACT_DEC: r.value = a - 1;
			fpa_pkg::ACT_I2F: r.value = a << FRAC;
			fpa_pkg::ACT_F2I: r.value = a >>> FRAC;
			default: r.value = '0;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_cycles > 0)
			hold_cycles <= hold_cycles - 1;
		pop <= arst_n && hold_cycles <= 1 && $urandom_range(99) >= recv_stall_pct;
	end

	always @(posedge clk) begin
		alu_answer_t want;
		if (arst_n && pop && !empty) begin
			beats_checked++;
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", result);
			end else begin
				want = answers_due.pop_front();
				if (want.value !== result || want.lt !== a_less || want.eq !== a_equal
						|| want.gt !== a_greater || want.dz !== div_by_zero) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h %b%b%b%b got %h %b%b%b%b",
							want.value, want.lt, want.eq, want.gt, want.dz, result,
							a_less, a_equal, a_greater, div_by_zero);
				end
			end
		end
	end

	task automatic send_beat(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		action <= op;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		answers_due.push_back(compute_alu(op, a, b));
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_operand();
		case ($urandom_range(7))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $signed(32'($urandom_range(0, 2)) - 1);
			3: return $signed(32'($urandom_range(0, 2047)) - 1024);
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic test_directed();
		logic signed [31:0] edges[6] = '{32'sh7FFFFFFF, 32'sh80000000, 0, 1, -1, 32'sh100};
		for (int op = 0; op < 16; op++)
			send_beat(op[3:0], edges[op % 6], edges[(op + 2) % 6]);
		send_beat(fpa_pkg::ACT_DIV, 32'sh80000000, -1);
		send_beat(fpa_pkg::ACT_DIV, 32'sh12345, 0);
		send_beat(fpa_pkg::ACT_MUL, 32'sh80000000, 32'sh80000000);
		send_beat(fpa_pkg::ACT_F2I, -1, 0);
		send_beat(fpa_pkg::ACT_I2F, 32'sh7FFFFFFF, 0);
		send_beat(fpa_pkg::ACT_MIN, 5, 5);
		wait_drained();
	endtask

	task automatic test_random(int count, int idle, int stall);
		logic [3:0] op;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(19) == 0) ? 4'($urandom_range(10, 15))
				: 4'($urandom_range(0, 9));
			send_beat(op, pick_operand(), ($urandom_range(15) == 0) ? 32'sd0
				: pick_operand());
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_cycles = 400;
		for (int i = 0; i < 12; i++)
			send_beat(4'($urandom_range(0, 9)), $signed($urandom), $signed($urandom));
		wait_drained();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(400, 0, 0);
		test_random(350, 78, 0);
		test_random(350, 0, 78);
		test_random(350, 8, 8);
		test_backpressure();
		test_random(50, 0, 0);
		repeat (200) @(posedge clk);
		$display("Covered %0d result beats over all ten operations, unused codes,", beats_checked);
		$display("divide by zero, extreme operands, idle/stall phases and a full-queue stall.");
		if (mismatches == 0 && answers_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fpa_pkg.sv
rtl/fpa_front.sv
rtl/fpa_queue.sv
rtl/fpa_back.sv
rtl/fixed_point_alu.sv
dv/testbench.sv
